### design/tlpc_pkg.sv
// Shared types and constants for the pedestrian traffic light controller.
`default_nettype none

package tlpc_pkg;

  localparam int unsigned TICKS_PER_SECOND = 10;
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] SUBTICK_LAST = CNT_W'(TICKS_PER_SECOND - 1);
  localparam logic [CNT_W-1:0] SINCE_MAX = '1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 4;

  typedef enum logic [3:0] {
    PH_RED          = 4'd0,
    PH_GREEN        = 4'd1,
    PH_YELLOW       = 4'd2,
    PH_CROSS_YELLOW = 4'd3,
    PH_CROSS_RED    = 4'd4,
    PH_BEEP         = 4'd5,
    PH_END          = 4'd6,
    PH_POST_GREEN   = 4'd7,
    PH_WAIT         = 4'd8
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED      = 3'd0,
    CFG_GREEN    = 3'd1,
    CFG_YELLOW   = 3'd2,
    CFG_WAIT     = 3'd3,
    CFG_WALK     = 3'd4,
    CFG_BEEP     = 3'd5,
    CFG_END      = 3'd6,
    CFG_DEBOUNCE = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] red_s;
    logic [CNT_W-1:0] green_s;
    logic [CNT_W-1:0] yellow_s;
    logic [CNT_W-1:0] wait_s;
    logic [CNT_W-1:0] walk_s;
    logic [CNT_W-1:0] beep_s;
    logic [CNT_W-1:0] end_s;
    logic [CNT_W-1:0] debounce;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    red_s:    4'd10,
    green_s:  4'd10,
    yellow_s: 4'd3,
    wait_s:   4'd2,
    walk_s:   4'd5,
    beep_s:   4'd5,
    end_s:    4'd2,
    debounce: 4'd3
  };

  typedef struct packed {
    phase_e           phase;
    logic [CNT_W-1:0] countdown;
    logic [CNT_W-1:0] subtick;
    logic [CNT_W-1:0] since_press;
    logic             await_rel;
    logic             lamp_red;
    logic             lamp_green;
    logic             buzzer;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_RED,
    countdown:   CFG_RESET.red_s,
    subtick:     4'd0,
    since_press: SINCE_MAX,
    await_rel:   1'b0,
    lamp_red:    1'b1,
    lamp_green:  1'b0,
    buzzer:      1'b0
  };

endpackage

`default_nettype wire

### design/tlpc_in_if.sv
// Input channel carrying one tick item with the pedestrian button level.
`default_nettype none

interface tlpc_in_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink (input valid, input button_pressed, output ready);
endinterface

`default_nettype wire

### design/tlpc_out_if.sv
// Output channel carrying one result item per tick.
`default_nettype none

interface tlpc_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       buzzer_on;
  logic [3:0] phase;
  logic [3:0] seconds_left;
  logic       second_elapsed;

  modport source (output valid, output red_on, output green_on, output buzzer_on,
                  output phase, output seconds_left, output second_elapsed,
                  input ready);
  modport sink (input valid, input red_on, input green_on, input buzzer_on,
                input phase, input seconds_left, input second_elapsed,
                output ready);
endinterface

`default_nettype wire

### design/tlpc_step.sv
// Next-state logic for one tick: debounce, divider and phase sequencing.
`default_nettype none

module tlpc_step (
  input  tlpc_pkg::state_t cur_i,
  input  tlpc_pkg::cfg_t   cfg_i,
  input  logic             pressed_i,
  output tlpc_pkg::state_t nxt_o,
  output logic             fired_o
);

  logic [tlpc_pkg::CNT_W-1:0] since_inc;
  logic                       press_ok;
  logic                       honoured;
  tlpc_pkg::state_t           dbn;
  tlpc_pkg::state_t           sec;

  always_comb begin
    since_inc = (cur_i.since_press != tlpc_pkg::SINCE_MAX) ?
                cur_i.since_press + 1'b1 : cur_i.since_press;
    press_ok  = pressed_i && !cur_i.await_rel && (since_inc >= cfg_i.debounce);
    honoured  = press_ok && (cur_i.phase == tlpc_pkg::PH_RED ||
                             cur_i.phase == tlpc_pkg::PH_GREEN ||
                             cur_i.phase == tlpc_pkg::PH_YELLOW);

    dbn             = cur_i;
    dbn.since_press = press_ok ? '0 : since_inc;
    dbn.await_rel   = pressed_i && (press_ok || cur_i.await_rel);
  end

  // One-second step on the debounced state
  always_comb begin
    sec = dbn;
    if (dbn.phase == tlpc_pkg::PH_BEEP) begin
      sec.buzzer = dbn.countdown[0];
    end
    if (dbn.countdown != '0) begin
      if (dbn.phase > tlpc_pkg::PH_WAIT) begin
        sec.phase      = tlpc_pkg::PH_RED;
        sec.countdown  = cfg_i.red_s;
        sec.lamp_red   = 1'b1;
        sec.lamp_green = 1'b0;
      end else begin
        sec.countdown = dbn.countdown - 1'b1;
      end
    end else begin
      unique case (dbn.phase)
        tlpc_pkg::PH_RED: begin
          sec.phase      = tlpc_pkg::PH_GREEN;
          sec.countdown  = cfg_i.green_s;
          sec.lamp_red   = 1'b0;
          sec.lamp_green = 1'b1;
        end
        tlpc_pkg::PH_GREEN: begin
          sec.phase      = tlpc_pkg::PH_YELLOW;
          sec.countdown  = cfg_i.yellow_s;
          sec.lamp_red   = 1'b1;
          sec.lamp_green = 1'b1;
        end
        tlpc_pkg::PH_WAIT: begin
          sec.phase      = tlpc_pkg::PH_CROSS_YELLOW;
          sec.countdown  = cfg_i.yellow_s;
          sec.lamp_red   = 1'b1;
          sec.lamp_green = 1'b1;
        end
        tlpc_pkg::PH_CROSS_YELLOW: begin
          sec.phase      = tlpc_pkg::PH_CROSS_RED;
          sec.countdown  = cfg_i.walk_s;
          sec.lamp_red   = 1'b1;
          sec.lamp_green = 1'b0;
        end
        tlpc_pkg::PH_CROSS_RED: begin
          sec.phase     = tlpc_pkg::PH_BEEP;
          sec.countdown = cfg_i.beep_s;
        end
        tlpc_pkg::PH_BEEP: begin
          sec.buzzer    = 1'b0;
          sec.phase     = tlpc_pkg::PH_END;
          sec.countdown = cfg_i.end_s;
        end
        tlpc_pkg::PH_END: begin
          sec.phase      = tlpc_pkg::PH_POST_GREEN;
          sec.countdown  = cfg_i.green_s;
          sec.lamp_red   = 1'b0;
          sec.lamp_green = 1'b1;
        end
        default: begin
          // yellow, post-crossing green and unused codes return to red
          sec.phase      = tlpc_pkg::PH_RED;
          sec.countdown  = cfg_i.red_s;
          sec.lamp_red   = 1'b1;
          sec.lamp_green = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    nxt_o   = dbn;
    fired_o = 1'b0;
    if (honoured) begin
      nxt_o.phase     = tlpc_pkg::PH_WAIT;
      nxt_o.countdown = cfg_i.wait_s;
      nxt_o.subtick   = '0;
    end else if (dbn.subtick >= tlpc_pkg::SUBTICK_LAST) begin
      nxt_o         = sec;
      nxt_o.subtick = '0;
      fired_o       = 1'b1;
    end else begin
      nxt_o.subtick = dbn.subtick + 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/traffic_light_pedestrian_controller_top.sv
// Top level of the pedestrian traffic light controller.
// Each input item is one 100 ms tick carrying the combined button level; each
// tick yields one result item with the lamp and buzzer drives, the phase, the
// remaining seconds and a flag for a completed one-second step. One item is
// accepted every clock cycle while results are taken; an accepted tick sits in
// the input register until the result register is free, then the combinational
// next-state logic feeds the result register, which presents its result. A
// result that waits holds the input side only once both registers are full.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module traffic_light_pedestrian_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tlpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  tlpc_in_if.sink                           in_ch_i,
  tlpc_out_if.source                        out_ch_o
);

  tlpc_pkg::cfg_t   cfg_q;
  tlpc_pkg::state_t state_q;
  tlpc_pkg::state_t state_d;
  logic             fired;
  logic             in_valid_q;
  logic             in_btn_q;
  logic             out_valid_q;
  logic             fired_q;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tlpc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (tlpc_pkg::cfg_idx_e'(cfg_idx_i))
        tlpc_pkg::CFG_RED:      cfg_q.red_s    <= cfg_wdata_i;
        tlpc_pkg::CFG_GREEN:    cfg_q.green_s  <= cfg_wdata_i;
        tlpc_pkg::CFG_YELLOW:   cfg_q.yellow_s <= cfg_wdata_i;
        tlpc_pkg::CFG_WAIT:     cfg_q.wait_s   <= cfg_wdata_i;
        tlpc_pkg::CFG_WALK:     cfg_q.walk_s   <= cfg_wdata_i;
        tlpc_pkg::CFG_BEEP:     cfg_q.beep_s   <= cfg_wdata_i;
        tlpc_pkg::CFG_END:      cfg_q.end_s    <= cfg_wdata_i;
        tlpc_pkg::CFG_DEBOUNCE: cfg_q.debounce <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tlpc_step u_step (
    .cur_i     (state_q),
    .cfg_i     (cfg_q),
    .pressed_i (in_btn_q),
    .nxt_o     (state_d),
    .fired_o   (fired)
  );

  // Input register: take a new item whenever the stage is empty or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      in_btn_q <= in_ch_i.button_pressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlpc_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fired_q <= fired;
    end
  end

  // The result fields mirror the committed state of the last item
  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.red_on         = state_q.lamp_red;
  assign out_ch_o.green_on       = state_q.lamp_green;
  assign out_ch_o.buzzer_on      = state_q.buzzer;
  assign out_ch_o.phase          = 4'(state_q.phase);
  assign out_ch_o.seconds_left   = state_q.countdown;
  assign out_ch_o.second_elapsed = fired_q;

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not filled after stage advance");

  a_red_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == tlpc_pkg::PH_RED || state_q.phase == tlpc_pkg::PH_CROSS_RED ||
     state_q.phase == tlpc_pkg::PH_BEEP || state_q.phase == tlpc_pkg::PH_END)
    |-> (state_q.lamp_red && !state_q.lamp_green))
    else $error("lamps disagree with a red phase");

  a_green_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == tlpc_pkg::PH_GREEN || state_q.phase == tlpc_pkg::PH_POST_GREEN)
    |-> (!state_q.lamp_red && state_q.lamp_green))
    else $error("lamps disagree with a green phase");

  a_buzzer_beep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.buzzer |-> (state_q.phase == tlpc_pkg::PH_BEEP))
    else $error("buzzer on outside the beeping phase");

  a_press_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.since_press == '0) |-> state_q.await_rel)
    else $error("accepted press without release wait");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the pedestrian traffic light controller top level.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic            red;
    logic            green;
    logic            buzzer;
    tlpc_pkg::phase_e phase;
    logic [3:0]      secs;
    logic            stepped;
  } lights_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [tlpc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tlpc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tlpc_in_if  in_ch ();
  tlpc_out_if out_ch ();

  traffic_light_pedestrian_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  // Controller mirror: timing registers and per-tick state.
  tlpc_pkg::cfg_t   timing;
  tlpc_pkg::phase_e cur_phase;
  logic [3:0]       secs_left;
  logic [3:0]       subtick;
  logic [3:0]       since_press;
  logic             await_release;
  logic             lamp_red;
  logic             lamp_green;
  logic             buzzer;

  lights_t pending_lights[$];
  lights_t got_lights;
  lights_t want_lights;

  bit          stall_enable;
  int unsigned ready_hold;
  int unsigned cycle_count;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned presses_honoured;
  int unsigned buzzer_seen;
  logic [8:0]  phases_seen;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic void reset_model();
    timing        = tlpc_pkg::CFG_RESET;
    cur_phase     = tlpc_pkg::PH_RED;
    secs_left     = tlpc_pkg::CFG_RESET.red_s;
    subtick       = '0;
    since_press   = 4'd15;
    await_release = 1'b0;
    lamp_red      = 1'b1;
    lamp_green    = 1'b0;
    buzzer        = 1'b0;
  endfunction

  function automatic void enter_phase(tlpc_pkg::phase_e ph, logic [3:0] start, logic r,
                                      logic g);
    cur_phase  = ph;
    secs_left  = start;
    lamp_red   = r;
    lamp_green = g;
  endfunction

  // One-second step: count down, or move on when the countdown is already zero.
  function automatic void count_second();
    logic was_zero;
    was_zero = (secs_left == 4'd0);
    if (cur_phase == tlpc_pkg::PH_BEEP) buzzer = secs_left[0];
    if (!was_zero) begin
      secs_left = secs_left - 4'd1;
      return;
    end
    case (cur_phase)
      tlpc_pkg::PH_RED:
        enter_phase(tlpc_pkg::PH_GREEN, timing.green_s, 1'b0, 1'b1);
      tlpc_pkg::PH_GREEN:
        enter_phase(tlpc_pkg::PH_YELLOW, timing.yellow_s, 1'b1, 1'b1);
      tlpc_pkg::PH_YELLOW:
        enter_phase(tlpc_pkg::PH_RED, timing.red_s, 1'b1, 1'b0);
      tlpc_pkg::PH_WAIT:
        enter_phase(tlpc_pkg::PH_CROSS_YELLOW, timing.yellow_s, 1'b1, 1'b1);
      tlpc_pkg::PH_CROSS_YELLOW:
        enter_phase(tlpc_pkg::PH_CROSS_RED, timing.walk_s, 1'b1, 1'b0);
      tlpc_pkg::PH_CROSS_RED:
        enter_phase(tlpc_pkg::PH_BEEP, timing.beep_s, lamp_red, lamp_green);
      tlpc_pkg::PH_BEEP: begin
        buzzer = 1'b0;
        enter_phase(tlpc_pkg::PH_END, timing.end_s, lamp_red, lamp_green);
      end
      tlpc_pkg::PH_END:
        enter_phase(tlpc_pkg::PH_POST_GREEN, timing.green_s, 1'b0, 1'b1);
      default:
        enter_phase(tlpc_pkg::PH_RED, timing.red_s, 1'b1, 1'b0);
    endcase
  endfunction

  function automatic lights_t predict_tick(logic pressed);
    lights_t res;
    logic    honoured;
    logic    stepped;
    honoured = 1'b0;
    stepped  = 1'b0;
    if (since_press != 4'd15) since_press = since_press + 4'd1;
    if (pressed) begin
      if (!await_release && since_press >= timing.debounce) begin
        if (cur_phase == tlpc_pkg::PH_RED || cur_phase == tlpc_pkg::PH_GREEN ||
            cur_phase == tlpc_pkg::PH_YELLOW) begin
          cur_phase = tlpc_pkg::PH_WAIT;
          secs_left = timing.wait_s;
          subtick   = '0;
          honoured  = 1'b1;
          presses_honoured++;
        end
        await_release = 1'b1;
        since_press   = '0;
      end
    end else begin
      await_release = 1'b0;
    end
    if (!honoured) begin
      if (subtick >= 4'(tlpc_pkg::TICKS_PER_SECOND - 1)) begin
        subtick = '0;
        stepped = 1'b1;
        count_second();
      end else begin
        subtick = subtick + 4'd1;
      end
    end
    res.red     = lamp_red;
    res.green   = lamp_green;
    res.buzzer  = buzzer;
    res.phase   = cur_phase;
    res.secs    = secs_left;
    res.stepped = stepped;
    return res;
  endfunction

  // Result side: random stall bursts while stalls are enabled.
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ch.ready <= 1'b0;
    end else if (stall_enable && $urandom_range(0, 4) == 0) begin
      ready_hold = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_lights.red     = out_ch.red_on;
      got_lights.green   = out_ch.green_on;
      got_lights.buzzer  = out_ch.buzzer_on;
      got_lights.phase   = tlpc_pkg::phase_e'(out_ch.phase);
      got_lights.secs    = out_ch.seconds_left;
      got_lights.stepped = out_ch.second_elapsed;
      if (pending_lights.size() == 0) begin
        if (mismatches < 10) $display("unexpected result item: %p", got_lights);
        mismatches++;
      end else begin
        want_lights = pending_lights.pop_front();
        results_checked++;
        if (got_lights.phase <= tlpc_pkg::PH_WAIT) phases_seen[got_lights.phase] = 1'b1;
        if (got_lights.buzzer === 1'b1) buzzer_seen++;
        if (got_lights.red !== want_lights.red || got_lights.green !== want_lights.green ||
            got_lights.buzzer !== want_lights.buzzer ||
            got_lights.phase !== want_lights.phase ||
            got_lights.secs !== want_lights.secs ||
            got_lights.stepped !== want_lights.stepped) begin
          if (mismatches < 10) begin
            $display("mismatch at result %0d: expected %p", results_checked, want_lights);
            $display("                        actual   %p", got_lights);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_lights.size());
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_tick(input logic pressed);
    int unsigned gap;
    gap = (stall_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.button_pressed <= pressed;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_lights.push_back(predict_tick(pressed));
    ticks_sent++;
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty.
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_lights.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input tlpc_pkg::cfg_idx_e idx, input logic [3:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      tlpc_pkg::CFG_RED:      timing.red_s    = val;
      tlpc_pkg::CFG_GREEN:    timing.green_s  = val;
      tlpc_pkg::CFG_YELLOW:   timing.yellow_s = val;
      tlpc_pkg::CFG_WAIT:     timing.wait_s   = val;
      tlpc_pkg::CFG_WALK:     timing.walk_s   = val;
      tlpc_pkg::CFG_BEEP:     timing.beep_s   = val;
      tlpc_pkg::CFG_END:      timing.end_s    = val;
      tlpc_pkg::CFG_DEBOUNCE: timing.debounce = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input logic [3:0] red, input logic [3:0] green,
                            input logic [3:0] yellow, input logic [3:0] wait_s,
                            input logic [3:0] walk, input logic [3:0] beep,
                            input logic [3:0] end_s, input logic [3:0] debounce);
    cfg_write(tlpc_pkg::CFG_RED, red);
    cfg_write(tlpc_pkg::CFG_GREEN, green);
    cfg_write(tlpc_pkg::CFG_YELLOW, yellow);
    cfg_write(tlpc_pkg::CFG_WAIT, wait_s);
    cfg_write(tlpc_pkg::CFG_WALK, walk);
    cfg_write(tlpc_pkg::CFG_BEEP, beep);
    cfg_write(tlpc_pkg::CFG_END, end_s);
    cfg_write(tlpc_pkg::CFG_DEBOUNCE, debounce);
  endtask

  function automatic logic [3:0] pick_seconds();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
  endfunction

  // Mostly clean press pulses with random hold and gap; some raw noise ticks.
  task automatic run_requests(input int unsigned n_items);
    int unsigned sent;
    int unsigned hold;
    int unsigned gap;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        send_tick(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        hold = $urandom_range(1, 3);
        gap  = $urandom_range(0, 25);
        for (int unsigned i = 0; i < hold && sent < n_items; i++) begin
          send_tick(1'b1);
          sent++;
        end
        for (int unsigned i = 0; i < gap && sent < n_items; i++) begin
          send_tick(1'b0);
          sent++;
        end
      end
    end
  endtask

  // Reset timing: press honoured in red, held press, press during the request
  // wait, and a press rejected by the debounce window.
  task automatic test_press_debounce();
    logic [19:0] pattern;
    pattern = 20'b00011101010001001100;
    for (int i = 19; i >= 0; i--) send_tick(pattern[i]);
    settle();
  endtask

  // All zero: every phase lasts one step and debounce never blocks.
  task automatic test_zero_durations();
    set_timing(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    repeat (25) send_tick(1'b0);
    send_tick(1'b1);
    repeat (80) send_tick(1'b0);
    settle();
  endtask

  task automatic test_max_durations();
    set_timing(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
    run_requests(200);
    settle();
  endtask

  task automatic test_random_timings();
    repeat (4) begin
      set_timing(pick_seconds(), pick_seconds(), pick_seconds(), pick_seconds(),
                 pick_seconds(), pick_seconds(), pick_seconds(), 4'($urandom_range(0, 15)));
      run_requests(90);
      settle();
    end
  endtask

  // No gaps on either side: one tick per clock.
  task automatic test_back_to_back();
    stall_enable = 1'b0;
    set_timing(4'd1, 4'd2, 4'd1, 4'd0, 4'd1, 4'd3, 4'd1, 4'd2);
    run_requests(60);
    settle();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = tlpc_pkg::CFG_RED;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.button_pressed = 1'b0;
    out_ch.ready         = 1'b0;
    stall_enable         = 1'b1;
    ready_hold           = 0;
    cycle_count          = 0;
    ticks_sent           = 0;
    results_checked      = 0;
    mismatches           = 0;
    presses_honoured     = 0;
    buzzer_seen          = 0;
    phases_seen          = '0;
    reset_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_press_debounce();
    test_zero_durations();
    test_max_durations();
    test_random_timings();
    test_back_to_back();

    if (pending_lights.size() != 0) mismatches++;
    $display("%0d ticks sent, %0d results checked, %0d presses honoured",
             ticks_sent, results_checked, presses_honoured);
    $display("phases reached (bit per code) %b, buzzer on in %0d results, %0d mismatches",
             phases_seen, buzzer_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
